FILE: rtl/argb_linear_gradient_pixel_macros.svh
// Assertion macros for the ARGB linear gradient pixel block.
// Depends on nothing; the asserting module must provide aclk and aresetn.
`ifndef ARGB_LINEAR_GRADIENT_PIXEL_MACROS_SVH
`define ARGB_LINEAR_GRADIENT_PIXEL_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define AGP_CHECK(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("gradient pixel check failed");

// Checks that a condition in one cycle is followed by another in the next.
`define AGP_NEXT(lbl, pre, post) \
    `AGP_CHECK(lbl, (pre) |=> (post))

`endif

FILE: rtl/agp_pkg.sv
// Shared constants, register codes and pipeline stage types of the gradient pixel block.
// Depends on nothing.
`timescale 1ns / 1ps
package agp_pkg;

    localparam int MAX_LENGTH = 4096;
    localparam int LEN_W      = 13;
    localparam int IDX_W      = 12;
    localparam int COLOR_W    = 32;
    localparam int DEN_W      = $clog2(8 * MAX_LENGTH);
    localparam int TOT_W      = DEN_W + 8;
    localparam int DIV_STEPS  = 8;

    typedef enum logic [1:0] {
        MODE_DL  = 2'd0,
        MODE_LD  = 2'd1,
        MODE_DLD = 2'd2,
        MODE_LDL = 2'd3
    } agp_mode_t;

    typedef enum logic [2:0] {
        REG_START  = 3'd0,
        REG_END    = 3'd1,
        REG_LENGTH = 3'd2,
        REG_MODE   = 3'd3,
        REG_LIGHT  = 3'd4
    } agp_reg_t;

    typedef struct packed {
        logic [COLOR_W-1:0] start_color;
        logic [COLOR_W-1:0] end_color;
        logic [LEN_W-1:0]   length;
        agp_mode_t          mode;
        logic               light;
    } agp_cfg_t;

    typedef struct packed {
        logic               ok;
        logic [DEN_W-1:0]   num;
        logic [DEN_W-1:0]   den;
        logic [COLOR_W-1:0] cs;
        logic [COLOR_W-1:0] ce;
    } agp_front_t;

    typedef struct packed {
        logic                  ok;
        logic [DEN_W-1:0]      den;
        logic [3:0][TOT_W-1:0] rem;
        logic [3:0][7:0]       quo;
    } agp_div_t;

endpackage

FILE: rtl/agp_front.sv
// First stage: ramp position, blend fraction and end colours of one item.
// Depends on agp_pkg.
`timescale 1ns / 1ps
module agp_front
    import agp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  agp_cfg_t         cfg,
    input  logic             in_valid,
    input  logic [IDX_W-1:0] pixel_index,
    output logic             out_valid,
    output agp_front_t       out_data
);

    logic             valid_reg;
    agp_front_t       data_reg;
    agp_front_t       data_next;
    logic [LEN_W-1:0] len_c;
    logic [LEN_W:0]   len1;
    logic [LEN_W-1:0] h;
    logic [LEN_W-1:0] steps;
    logic [LEN_W-1:0] idx;
    logic [LEN_W-1:0] pos;
    logic [LEN_W-1:0] pos_c;
    logic             sym;
    logic             swap;
    logic             ok;

    always_comb begin
        len_c = ({19'd0, cfg.length} > MAX_LENGTH) ? LEN_W'(MAX_LENGTH) : cfg.length;
        idx   = LEN_W'(pixel_index);
        ok    = idx < len_c;
        sym   = (cfg.mode == MODE_DLD) || (cfg.mode == MODE_LDL);
        swap  = (cfg.mode == MODE_LD) || (cfg.mode == MODE_LDL);
        len1  = {1'b0, len_c} + 1'b1;
        h     = sym ? len1[LEN_W:1] : len_c;
        steps = (h > LEN_W'(2)) ? h - 1'b1 : LEN_W'(1);
        pos   = (idx < h) ? idx : len_c - 1'b1 - idx;
        pos_c = (pos > steps) ? steps : pos;
        data_next.ok  = ok;
        data_next.den = DEN_W'(steps) << 3;
        if (cfg.light) begin
            data_next.num = DEN_W'(steps) + (DEN_W'(pos_c) << 2) + (DEN_W'(pos_c) << 1);
        end else begin
            data_next.num = DEN_W'(pos_c) << 3;
        end
        data_next.cs = ok ? (swap ? cfg.end_color : cfg.start_color) : '0;
        data_next.ce = ok ? (swap ? cfg.start_color : cfg.end_color) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
        if (adv) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: rtl/agp_blend.sv
// Second stage: weighted sum of the two end values for each of the four channels.
// Depends on agp_pkg.
`timescale 1ns / 1ps
module agp_blend
    import agp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       adv,
    input  logic       in_valid,
    input  agp_front_t in_data,
    output logic       out_valid,
    output agp_div_t   out_data
);

    logic       valid_reg;
    agp_div_t   data_reg;
    agp_div_t   data_next;
    logic [DEN_W-1:0] inv;

    always_comb begin
        inv = in_data.den - in_data.num;
        data_next.ok  = in_data.ok;
        data_next.den = in_data.den;
        data_next.quo = '0;
        for (int k = 0; k < 4; k++) begin
            data_next.rem[k] = TOT_W'(in_data.cs[8*k +: 8]) * TOT_W'(inv)
                             + TOT_W'(in_data.ce[8*k +: 8]) * TOT_W'(in_data.num);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
        if (adv) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: rtl/agp_divstep.sv
// One restoring division stage: yields one quotient bit for each of the four channels.
// Depends on agp_pkg.
`timescale 1ns / 1ps
module agp_divstep
    import agp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       adv,
    input  logic [2:0] step_bit,
    input  logic       in_valid,
    input  agp_div_t   in_data,
    output logic       out_valid,
    output agp_div_t   out_data
);

    logic             valid_reg;
    agp_div_t         data_reg;
    agp_div_t         data_next;
    logic [TOT_W-1:0] trial;

    always_comb begin
        trial     = TOT_W'(in_data.den) << step_bit;
        data_next = in_data;
        for (int k = 0; k < 4; k++) begin
            if (in_data.rem[k] >= trial) begin
                data_next.rem[k]           = in_data.rem[k] - trial;
                data_next.quo[k][step_bit] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
        if (adv) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: rtl/argb_linear_gradient_pixel.sv
// ARGB8888 linear gradient pixel generator: one colour per pixel index.
// One item per cycle while the output is not stalled (m_tvalid high with m_tready low).
// The rate is set by a ten-stage pipeline: front end, channel blend and eight division stages.
// A stall freezes every stage at once, so nothing is lost or repeated.
// Synchronous active-low reset clears the stage valid bits and returns the configuration registers to reset values.
`timescale 1ns / 1ps
`include "argb_linear_gradient_pixel_macros.svh"
module argb_linear_gradient_pixel
    import agp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // pixel_index [11:0], zero fill [15:12]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // pixel_color [31:0]
    output logic        m_tuser   // index_valid [0]
);

    agp_cfg_t   cfg_reg;
    logic       adv;
    logic       front_v;
    agp_front_t front_d;
    logic       blend_v;
    logic       div_v [0:DIV_STEPS];
    agp_div_t   div_d [0:DIV_STEPS];
    agp_reg_t   reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = agp_reg_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_color <= '0;
            cfg_reg.end_color   <= '0;
            cfg_reg.length      <= LEN_W'(1);
            cfg_reg.mode        <= MODE_DL;
            cfg_reg.light       <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_sel)
                REG_START:  cfg_reg.start_color <= pwdata;
                REG_END:    cfg_reg.end_color   <= pwdata;
                REG_LENGTH: cfg_reg.length      <= pwdata[LEN_W-1:0];
                REG_MODE:   cfg_reg.mode        <= agp_mode_t'(pwdata[1:0]);
                REG_LIGHT:  cfg_reg.light       <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_START:  prdata = cfg_reg.start_color;
            REG_END:    prdata = cfg_reg.end_color;
            REG_LENGTH: prdata = 32'(cfg_reg.length);
            REG_MODE:   prdata = 32'(cfg_reg.mode);
            REG_LIGHT:  prdata = 32'(cfg_reg.light);
            default:    prdata = '0;
        endcase
    end

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    agp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .cfg         (cfg_reg),
        .in_valid    (s_tvalid),
        .pixel_index (s_tdata[IDX_W-1:0]),
        .out_valid   (front_v),
        .out_data    (front_d)
    );

    agp_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (front_v),
        .in_data   (front_d),
        .out_valid (blend_v),
        .out_data  (div_d[0])
    );

    assign div_v[0] = blend_v;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        agp_divstep u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .step_bit  (3'(DIV_STEPS - 1 - g)),
            .in_valid  (div_v[g]),
            .in_data   (div_d[g]),
            .out_valid (div_v[g+1]),
            .out_data  (div_d[g+1])
        );
    end

    assign m_tvalid = div_v[DIV_STEPS];
    assign m_tdata  = div_d[DIV_STEPS].quo;
    assign m_tuser  = div_d[DIV_STEPS].ok;

    `AGP_CHECK(a_zero_when_out_of_range, m_tvalid && !m_tuser |-> m_tdata == '0)
    `AGP_NEXT(a_front_to_blend, adv && front_v, blend_v)
    `AGP_NEXT(a_last_to_output, adv && div_v[DIV_STEPS-1], m_tvalid)

endmodule
